### design/fmgi_pkg.sv
package fmgi_pkg;

    localparam int ADDR_W      = 15;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = 8;
    localparam int NTERM       = 10;
    localparam int NPOINT      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 208;
    localparam int OUT_DATA_W  = 96;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Z = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [2:0][31:0] origin;
        logic [2:0][30:0] inv_step;
    } cfg_t;

    typedef struct packed {
        logic                         query;
        logic                         inb;
        logic                         mirror;
        logic [ADDR_W-1:0]            addr;
        logic [3*DATA_W-1:0]          data;
        logic [NTERM-1:0][FRAC_W-1:0] wgt;
    } item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LO,
        F_HI,
        F_EVAL,
        F_WGT,
        F_PQR,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_CALC,
        B_OUT
    } back_state_t;

endpackage

### design/fmgi_front.sv
module fmgi_front
    import fmgi_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  cfg_t                 cfg,
    output logic                 push,
    input  logic                 full,
    output item_t                item
);

    front_state_t state_reg, state_next;
    logic [1:0]   axis_reg;

    logic                         query_reg;
    logic                         inb_reg;
    logic                         mirror_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [3*DATA_W-1:0]          data_reg;
    logic signed [32:0]           pos_reg [3];
    logic signed [50:0]           lo_reg;
    logic signed [50:0]           prod_reg;
    logic [2:0][IDX_W-1:0]        idx_reg;
    logic [2:0][FRAC_W-1:0]       fr_reg;
    logic [NTERM-1:0][FRAC_W-1:0] wgt_reg;

    logic signed [33:0] diff;
    logic        [16:0] mul_part;
    logic signed [50:0] prod_c;
    logic signed [66:0] f;
    logic        [34:0] lim;
    logic               axis_ok;
    logic        [31:0] m_pp, m_qq, m_rr, m_pq, m_qr, m_pr, m_pqr;
    logic        [ADDR_W-1:0] base;

    assign diff     = 34'(pos_reg[axis_reg])
                    - 34'($signed(cfg.origin[axis_reg]));
    assign mul_part = (state_reg == F_LO) ? {1'b0, cfg.inv_step[axis_reg][15:0]}
                                          : {2'b0, cfg.inv_step[axis_reg][30:16]};
    assign prod_c   = diff * $signed(mul_part);
    assign f        = {{16{lo_reg[50]}}, lo_reg} + {prod_reg, 16'b0};

    always_comb
    begin
        case (axis_reg)
            2'd0:    lim = 35'(GRID_X - 2);
            2'd1:    lim = 35'(GRID_Y - 2);
            default: lim = 35'(GRID_Z - 2);
        endcase
    end

    assign axis_ok = !f[66] && (f[66:32] != '0) && (f[66:32] <= lim);

    assign m_pp  = fr_reg[0] * fr_reg[0];
    assign m_qq  = fr_reg[1] * fr_reg[1];
    assign m_rr  = fr_reg[2] * fr_reg[2];
    assign m_pq  = fr_reg[0] * fr_reg[1];
    assign m_qr  = fr_reg[1] * fr_reg[2];
    assign m_pr  = fr_reg[0] * fr_reg[2];
    assign m_pqr = wgt_reg[6] * fr_reg[2];
    assign base  = ADDR_W'(32'(idx_reg[0]) + 32'(GRID_X) * 32'(idx_reg[1])
                 + 32'(GRID_X * GRID_Y) * 32'(idx_reg[2]));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (s_tvalid)
                    state_next = (s_tuser == FUNC_QUERY) ? F_LO : F_PUSH;
            F_LO:   state_next = F_HI;
            F_HI:   state_next = F_EVAL;
            F_EVAL: state_next = (axis_reg == 2'd2) ? F_WGT : F_LO;
            F_WGT:  state_next = F_PQR;
            F_PQR:  state_next = F_PUSH;
            F_PUSH:
                if (!full)
                    state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == F_IDLE);
        push     = (state_reg == F_PUSH) && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_IDLE)
                axis_reg <= 2'd0;
            else if (state_reg == F_EVAL && axis_reg != 2'd2)
                axis_reg <= axis_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
                if (s_tvalid)
                begin
                    query_reg  <= s_tuser;
                    inb_reg    <= 1'b1;
                    addr_reg   <= s_tdata[14:0];
                    data_reg   <= s_tdata[110:15];
                    mirror_reg <= s_tdata[174];
                    pos_reg[0] <= 33'($signed(s_tdata[142:111]));
                    pos_reg[1] <= s_tdata[174] ? 33'sd0 - 33'($signed(s_tdata[174:143]))
                                               : 33'($signed(s_tdata[174:143]));
                    pos_reg[2] <= 33'($signed(s_tdata[206:175]));
                end
            F_LO:
                prod_reg <= prod_c;
            F_HI:
            begin
                lo_reg   <= prod_reg;
                prod_reg <= prod_c;
            end
            F_EVAL:
            begin
                if (!axis_ok)
                    inb_reg <= 1'b0;
                idx_reg[axis_reg] <= f[32 +: IDX_W];
                fr_reg[axis_reg]  <= f[31:16];
            end
            F_WGT:
            begin
                wgt_reg[0] <= fr_reg[0];
                wgt_reg[1] <= m_pp[31:16];
                wgt_reg[2] <= fr_reg[1];
                wgt_reg[3] <= m_qq[31:16];
                wgt_reg[4] <= fr_reg[2];
                wgt_reg[5] <= m_rr[31:16];
                wgt_reg[6] <= m_pq[31:16];
                wgt_reg[7] <= m_qr[31:16];
                wgt_reg[8] <= m_pr[31:16];
                addr_reg   <= base;
            end
            F_PQR:
                wgt_reg[9] <= m_pqr[31:16];
            default:
                ;
        endcase
    end

    always_comb
    begin
        item.query  = query_reg;
        item.inb    = inb_reg;
        item.mirror = mirror_reg;
        item.addr   = addr_reg;
        item.data   = data_reg;
        item.wgt    = wgt_reg;
    end

endmodule

### design/fmgi_fifo.sv
module fmgi_fifo
    import fmgi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### design/fmgi_back.sv
module fmgi_back
    import fmgi_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    localparam int PLANE = GRID_X * GRID_Y;

    back_state_t state_reg, state_next;
    logic [3:0]  cnt_reg;
    item_t       cur_reg;

    logic [3*DATA_W-1:0] mem [STORE_DEPTH];
    logic [3*DATA_W-1:0] rd_reg;
    logic [3*DATA_W-1:0] pts_reg [NPOINT];

    logic signed [36:0] coef_reg [3];
    logic        [15:0] w_reg;
    logic               dbl_reg;
    logic               dbl2_reg;
    logic signed [53:0] prod_reg [3];
    logic signed [59:0] acc_reg [3];

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    logic [ADDR_W-1:0]   offset;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    logic signed [36:0]  pv [3][NPOINT];
    logic signed [36:0]  cf [3][NTERM];
    logic                load_out;
    logic [OUT_DATA_W-1:0] result;

    always_comb
    begin
        case (cnt_reg)
            4'd1:    offset = ADDR_W'(PLANE);
            4'd2:    offset = ADDR_W'(-PLANE);
            4'd3:    offset = ADDR_W'(GRID_X);
            4'd4:    offset = ADDR_W'(-GRID_X);
            4'd5:    offset = ADDR_W'(1);
            4'd6:    offset = ADDR_W'(-1);
            4'd7:    offset = ADDR_W'(GRID_X + PLANE);
            4'd8:    offset = ADDR_W'(1 + PLANE);
            4'd9:    offset = ADDR_W'(1 + GRID_X);
            4'd10:   offset = ADDR_W'(1 + GRID_X + PLANE);
            default: offset = '0;
        endcase
    end

    assign mem_addr = (state_reg == B_IDLE) ? head.addr : cur_reg.addr + offset;
    assign mem_we   = (state_reg == B_IDLE) && !empty && (head.query == FUNC_WRITE);
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= head.data;
        rd_reg <= mem[mem_addr];
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < NPOINT; k++)
                pv[c][k] = 37'($signed(pts_reg[k][32*c +: 32]));
            cf[c][0] = pv[c][5] - pv[c][6];
            cf[c][1] = pv[c][5] + pv[c][6] - 2 * pv[c][0];
            cf[c][2] = pv[c][3] - pv[c][4];
            cf[c][3] = pv[c][3] + pv[c][4] - 2 * pv[c][0];
            cf[c][4] = pv[c][1] - pv[c][2];
            cf[c][5] = pv[c][1] + pv[c][2] - 2 * pv[c][0];
            cf[c][6] = pv[c][0] - pv[c][5] + pv[c][9] - pv[c][3];
            cf[c][7] = pv[c][0] - pv[c][3] + pv[c][7] - pv[c][1];
            cf[c][8] = pv[c][0] - pv[c][1] + pv[c][8] - pv[c][5];
            cf[c][9] = pv[c][1] - cf[c][6] - pv[c][7] - pv[c][8] + pv[c][10];
        end
    end

    always_comb
    begin
        logic signed [59:0] rnd;
        logic signed [43:0] v;
        result = '0;
        for (int c = 0; c < 3; c++)
        begin
            rnd = (acc_reg[c] + 60'sd65536) >>> 17;
            v   = 44'($signed(pts_reg[0][32*c +: 32])) + rnd[43:0];
            if (cur_reg.mirror && c != 1)
                v = 44'sd0 - v;
            if (v > 44'sd2147483647)
                result[32*c +: 32] = 32'h7FFF_FFFF;
            else if (v < -44'sd2147483648)
                result[32*c +: 32] = 32'h8000_0000;
            else
                result[32*c +: 32] = v[31:0];
        end
        if (!cur_reg.inb)
            result = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!empty && head.query == FUNC_QUERY)
                    state_next = head.inb ? B_READ : B_OUT;
            B_READ:
                if (cnt_reg == 4'd11)
                    state_next = B_CALC;
            B_CALC:
                if (cnt_reg == 4'd11)
                    state_next = B_OUT;
            B_OUT:
                if (load_out)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop = (state_reg == B_IDLE) && !empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= 4'd0;
            else
                cnt_reg <= cnt_reg + 4'd1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (state_reg == B_READ)
        begin
            if (cnt_reg != 4'd0)
                pts_reg[cnt_reg - 4'd1] <= rd_reg;
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= '0;
        end
        if (state_reg == B_CALC)
        begin
            if (cnt_reg < 4'd10)
            begin
                for (int c = 0; c < 3; c++)
                    coef_reg[c] <= cf[c][cnt_reg];
                w_reg   <= cur_reg.wgt[cnt_reg];
                dbl_reg <= (cnt_reg >= 4'd6);
            end
            if (cnt_reg >= 4'd1 && cnt_reg <= 4'd10)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[c] <= coef_reg[c] * $signed({1'b0, w_reg});
                dbl2_reg <= dbl_reg;
            end
            if (cnt_reg >= 4'd2)
            begin
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= acc_reg[c] + (dbl2_reg ? 60'(prod_reg[c]) <<< 1
                                                         : 60'(prod_reg[c]));
            end
        end
        if (load_out)
        begin
            out_data_reg <= result;
            out_user_reg <= cur_reg.inb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### design/field_map_grid_interpolator.sv
// Write item: the front end pushes it to the FIFO and the back end writes it to the store.
// Query item: in the front end, two partial multiplies and a bounds check per axis, then
// weights; in the back end, for an in-bounds query, 11 reads from the single-port store
// and 10 accumulation steps per component, then output. The back end takes one query at
// a time; the front end takes a new item only after pushing the last into the 2-entry FIFO.
// Reset clears control state and origins, sets inverse steps to 65536; store undefined.
module field_map_grid_interpolator
    import fmgi_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_index, point_bx, point_by, point_bz, query_x, query_y, query_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // field_x, field_y, field_z
    output logic [OUT_DATA_W-1:0] m_tdata,
    // in_bounds
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [31:0]           cfg_data
);

    cfg_t  cfg_reg;
    item_t front_item;
    item_t head;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin   <= '0;
            cfg_reg.inv_step <= {3{31'd65536}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ORIGIN_X:   cfg_reg.origin[0]   <= cfg_data;
                CFG_ORIGIN_Y:   cfg_reg.origin[1]   <= cfg_data;
                CFG_ORIGIN_Z:   cfg_reg.origin[2]   <= cfg_data;
                CFG_INV_STEP_X: cfg_reg.inv_step[0] <= cfg_data[30:0];
                CFG_INV_STEP_Y: cfg_reg.inv_step[1] <= cfg_data[30:0];
                CFG_INV_STEP_Z: cfg_reg.inv_step[2] <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    fmgi_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .item     (front_item)
    );

    fmgi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    fmgi_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
